>>> rtl/png_chunk_stream_checker_macros.svh
// ---------------------------------------------------------------------------
// png chunk stream checker assertion macros
// clocked assertion helpers used by the checker rtl
// ---------------------------------------------------------------------------
`ifndef PNG_CHUNK_STREAM_CHECKER_MACROS_SVH
`define PNG_CHUNK_STREAM_CHECKER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PNGCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PNGCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pngcs_pkg.sv
// ---------------------------------------------------------------------------
// png chunk stream checker package
// parser phases, status codes, parser state record and byte-level helpers
// ---------------------------------------------------------------------------
package pngcs_pkg;

  // chunk type codes, first byte most significant
  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  // reflected png crc-32 polynomial
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // result item packing
  localparam int unsigned OUT_FIELD_BITS = 147;
  localparam int unsigned OUT_DATA_BITS  = 152;

  // parser phases
  typedef enum logic [5:0] {
    PH_SIG  = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_TYPE = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CRC  = 6'b010000,
    PH_HALT = 6'b100000
  } phase_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_CRC  = 3'd1,
    ST_SIG  = 3'd2,
    ST_IHDR = 3'd3,
    ST_ZLIB = 3'd4
  } status_t;

  // complete parser state
  typedef struct packed {
    phase_t      phase;
    logic [30:0] cnt;
    logic [30:0] len;
    logic [31:0] typ;
    logic [31:0] crc;
    logic [23:0] rx;
    logic [30:0] width;
    logic [30:0] height;
    logic [7:0]  depth;
    logic [7:0]  ctype;
    logic [7:0]  cmf;
    logic [1:0]  flevel;
    logic        seen_idat;
    status_t     perr;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:     PH_SIG,
    cnt:       31'd0,
    len:       31'd0,
    typ:       32'd0,
    crc:       32'hFFFF_FFFF,
    rx:        24'd0,
    width:     31'd0,
    height:    31'd0,
    depth:     8'd0,
    ctype:     8'd0,
    cmf:       8'd0,
    flevel:    2'd0,
    seen_idat: 1'b0,
    perr:      ST_OK
  };

  // expected signature byte at a position
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'd137;
      3'd1:    v = 8'd80;
      3'd2:    v = 8'd78;
      3'd3:    v = 8'd71;
      3'd4:    v = 8'd13;
      3'd5:    v = 8'd10;
      3'd6:    v = 8'd26;
      3'd7:    v = 8'd10;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // one byte through the reflected crc-32
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // zlib header check: cm 8, cinfo below 8, no preset dictionary, multiple of 31
  function automatic logic zlib_ok(input logic [7:0] cmf, input logic [7:0] flg);
    logic [15:0] hdr;
    logic [6:0]  s1;
    logic [5:0]  s2;
    logic        mul31;
    hdr = {cmf, flg};
    // 32 is 1 modulo 31: fold 5-bit digits twice
    s1 = {2'd0, hdr[4:0]} + {2'd0, hdr[9:5]} + {2'd0, hdr[14:10]} + {6'd0, hdr[15]};
    s2 = {1'b0, s1[4:0]} + {4'd0, s1[6:5]};
    mul31 = (s2 == 6'd0) || (s2 == 6'd31);
    return (cmf[3:0] == 4'd8) && !cmf[7] && !flg[5] && mul31;
  endfunction

endpackage

>>> rtl/png_chunk_stream_checker.sv
// ---------------------------------------------------------------------------
// png chunk stream checker
// checks the png signature, frames chunks, verifies their crc and captures
// the ihdr fields and the zlib header of the first idat
// ---------------------------------------------------------------------------
// usage:
//   in_* carries one file byte per item in in_tdata[7:0]; in_tuser high marks
//   the first byte of a new file and restarts the parser before that byte.
//   out_* gives one result item per finished chunk (on its last crc byte)
//   or on the first byte that breaks the signature. out_tuser is the status,
//   out_tlast is high when the chunk was IEND and the parser stops.
//   after a nonzero status or IEND, bytes are dropped without results until
//   a byte arrives with in_tuser high.
// timing:
//   one item per cycle, sustained while out_tready stays high. a byte is
//   held in the input register, parsed by combinational logic (crc byte
//   update, field capture) and its result is registered in the output
//   register, from which out_tvalid and the result are driven.
//   when the receiver stalls, the output register holds its item; one more
//   byte waits in the input register, then in_tready falls.
// reset:
//   synchronous rst_n empties both registers and returns the parser to the
//   signature phase with all captured fields zero.
// ---------------------------------------------------------------------------
`include "png_chunk_stream_checker_macros.svh"

module png_chunk_stream_checker
  import pngcs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // input item channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] file_start
  // result item channel
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] chunk_type, [62:32] chunk_length, [93:63] image_width,
  // [124:94] image_height, [132:125] sample_depth, [140:133] color_mode,
  // [144:141] window_exponent, [146:145] compression_level, [151:147] zero
  output logic [151:0] out_tdata,
  output logic [2:0]   out_tuser,  // [2:0] status
  output logic         out_tlast   // image_end
);

  // input register
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       in_start_r;

  // parser state
  state_t st_r, st_nxt, cur;

  // result register
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_DATA_BITS-1:0] out_data_r;
  status_t                  out_status_r;
  logic                     out_last_r;

  logic        advance, process;
  logic        emit;
  status_t     emit_status;
  status_t     perr_fin;
  logic [30:0] cnt_inc;
  logic        crc_bad;

  // handshake: the input register moves on whenever the output can take a result
  assign advance   = !out_valid_r || out_tready;
  assign process   = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  assign in_valid_nxt  = in_tready ? in_tvalid : in_valid_r;
  assign out_valid_nxt = advance ? (process && emit) : out_valid_r;

  // parser step for the byte in the input register
  always_comb begin
    cur         = in_start_r ? STATE_RESET : st_r;
    st_nxt      = cur;
    emit        = 1'b0;
    emit_status = ST_OK;
    perr_fin    = cur.perr;
    crc_bad     = 1'b0;
    cnt_inc     = cur.cnt + 31'd1;
    case (cur.phase)
      PH_SIG: begin
        if (in_byte_r != sig_byte(cur.cnt[2:0])) begin
          st_nxt.phase = PH_HALT;
          emit         = 1'b1;
          emit_status  = ST_SIG;
        end else if (cur.cnt[2:0] == 3'd7) begin
          st_nxt.phase = PH_LEN;
          st_nxt.cnt   = 31'd0;
        end else begin
          st_nxt.cnt = cnt_inc;
        end
      end
      PH_LEN: begin
        st_nxt.len = {cur.len[22:0], in_byte_r};
        if (cur.cnt[1:0] == 2'd3) begin
          st_nxt.phase = PH_TYPE;
          st_nxt.cnt   = 31'd0;
        end else begin
          st_nxt.cnt = cnt_inc;
        end
      end
      PH_TYPE: begin
        st_nxt.crc = crc32_byte(cur.crc, in_byte_r);
        st_nxt.typ = {cur.typ[23:0], in_byte_r};
        if (cur.cnt[1:0] == 2'd3) begin
          st_nxt.cnt   = 31'd0;
          st_nxt.phase = (cur.len == 31'd0) ? PH_CRC : PH_DATA;
        end else begin
          st_nxt.cnt = cnt_inc;
        end
      end
      PH_DATA: begin
        st_nxt.crc = crc32_byte(cur.crc, in_byte_r);
        if (cur.typ == TYPE_IHDR) begin
          // ihdr field capture by byte position
          if (cur.cnt == 31'd0) begin
            st_nxt.width = {23'd0, in_byte_r};
          end else if (cur.cnt < 31'd4) begin
            st_nxt.width = {cur.width[22:0], in_byte_r};
          end else if (cur.cnt == 31'd4) begin
            st_nxt.height = {23'd0, in_byte_r};
          end else if (cur.cnt < 31'd8) begin
            st_nxt.height = {cur.height[22:0], in_byte_r};
          end else if (cur.cnt == 31'd8) begin
            st_nxt.depth = in_byte_r;
          end else if (cur.cnt == 31'd9) begin
            st_nxt.ctype = in_byte_r;
          end else if ((cur.cnt == 31'd10 || cur.cnt == 31'd12) && in_byte_r != 8'd0) begin
            // compression or interlace method not supported
            if (cur.perr == ST_OK) begin
              st_nxt.perr = ST_IHDR;
            end
          end
        end else if (cur.typ == TYPE_IDAT && !cur.seen_idat) begin
          // zlib header of the first idat
          if (cur.cnt == 31'd0) begin
            st_nxt.cmf = in_byte_r;
          end else if (cur.cnt == 31'd1) begin
            st_nxt.flevel = in_byte_r[7:6];
            if (!zlib_ok(cur.cmf, in_byte_r) && cur.perr == ST_OK) begin
              st_nxt.perr = ST_ZLIB;
            end
          end
        end
        if (cnt_inc == cur.len) begin
          st_nxt.phase = PH_CRC;
          st_nxt.cnt   = 31'd0;
        end else begin
          st_nxt.cnt = cnt_inc;
        end
      end
      PH_CRC: begin
        st_nxt.rx = {cur.rx[15:0], in_byte_r};
        if (cur.cnt[1:0] != 2'd3) begin
          st_nxt.cnt = cnt_inc;
        end else begin
          // chunk end: flag a first idat that is too short for a zlib header, check the crc, emit the result
          if (cur.typ == TYPE_IDAT && !cur.seen_idat) begin
            if (cur.len < 31'd2 && cur.perr == ST_OK) begin
              perr_fin = ST_ZLIB;
            end
            st_nxt.seen_idat = 1'b1;
          end
          crc_bad     = (~cur.crc) != {cur.rx, in_byte_r};
          emit        = 1'b1;
          emit_status = crc_bad ? ST_CRC : perr_fin;
          st_nxt.perr = perr_fin;
          if (emit_status != ST_OK || cur.typ == TYPE_IEND) begin
            st_nxt.phase = PH_HALT;
          end else begin
            st_nxt.phase = PH_LEN;
            st_nxt.cnt   = 31'd0;
            st_nxt.crc   = 32'hFFFF_FFFF;
            st_nxt.perr  = ST_OK;
          end
        end
      end
      PH_HALT: begin
        st_nxt = cur;
      end
      default: begin
        st_nxt.phase = PH_HALT;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= STATE_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (process) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser;
    end
    if (process && emit) begin
      out_data_r   <= {{(OUT_DATA_BITS - OUT_FIELD_BITS){1'b0}},
                       cur.flevel, cur.cmf[7:4], cur.ctype, cur.depth,
                       cur.height, cur.width, cur.len, cur.typ};
      out_status_r <= emit_status;
      out_last_r   <= (cur.typ == TYPE_IEND);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // assertions
  `PNGCS_ASSERT_NEXT(a_err_halts, process && emit && emit_status != ST_OK,
    st_r.phase == PH_HALT, "error result did not halt the parser")
  `PNGCS_ASSERT_NEXT(a_iend_halts, process && emit && cur.typ == TYPE_IEND,
    st_r.phase == PH_HALT, "iend result did not halt the parser")
  `PNGCS_ASSERT_NOW(a_halt_quiet, process && !in_start_r && st_r.phase == PH_HALT,
    !emit, "result produced while halted")
  `PNGCS_ASSERT_NEXT(a_emit_phase, process && emit,
    st_r.phase == PH_HALT || st_r.phase == PH_LEN, "unexpected phase after a result")
  `PNGCS_ASSERT_NEXT(a_result_loaded, process && emit, out_valid_r,
    "result was not loaded")

endmodule
